@@ rtl/core/rlbws_pkg.sv @@
// shared types, constants and helper functions for the rgb led write sequencer
// no dependencies; every other file of the block but rlbws_if imports this package
package rlbws_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ON   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF  = 2'd2;

    // mode selector codes
    localparam logic [7:0] MODE_SEL_TIMED = 8'd1;
    localparam logic [7:0] MODE_SEL_HW    = 8'd2;

    // driver register addresses
    localparam logic [3:0] ADDR_PERIOD = 4'd1;
    localparam logic [3:0] ADDR_DUTY   = 4'd2;
    localparam logic [3:0] ADDR_ENABLE = 4'd4;
    localparam logic [3:0] ADDR_RED    = 4'd6;
    localparam logic [3:0] ADDR_BLUE   = 4'd7;
    localparam logic [3:0] ADDR_GREEN  = 4'd8;
    localparam logic [3:0] ADDR_BLINK  = 4'd9;

    localparam logic [7:0] ENABLE_BIT = 8'h40;
    localparam logic [7:0] HW_PERIOD  = 8'h12;
    localparam logic [7:0] HW_DUTY    = 8'h32;
    localparam logic [7:0] BLINK_OFF  = 8'h06;
    localparam logic [7:0] DUTY_SAT   = 8'hFF;

    localparam logic [16:0] PERIOD_FIRST_MS = 17'd384;
    localparam logic [16:0] PERIOD_MAX_MS   = 17'd16380;
    localparam int          PERIOD_SHIFT    = 7;

    localparam logic [6:0] PCT_SCALE = 7'd100;
    // duty = pct * 25500 / 9960 = pct * 425 / 166
    localparam logic [8:0] DUTY_NUM   = 9'd425;
    localparam logic [8:0] DUTY_RECIP = 9'd394;
    localparam logic [7:0] DUTY_DEN   = 8'd166;

    typedef enum logic [1:0] {
        MODE_SOLID,
        MODE_TIMED,
        MODE_HW
    } mode_t;

    typedef struct packed {
        logic [7:0]  flash_mode_sel;
        logic [15:0] on_time_ms;
        logic [15:0] off_time_ms;
    } cfg_t;

    // item record through the front end and the divider
    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        blank;
        mode_t       mode;
        logic [16:0] p_sum;
        logic [22:0] rem;
        logic [6:0]  pct;
        logic [7:0]  period;
    } work_t;

    // everything the sequencer needs for one item
    typedef struct packed {
        logic [3:0] red_step;
        logic [3:0] green_step;
        logic [3:0] blue_step;
        logic       blank;
        logic       flash;
        logic [7:0] period;
        logic [7:0] duty;
        logic [7:0] enable;
    } seq_t;

    typedef struct packed {
        logic [3:0] addr;
        logic [7:0] value;
        logic       last;
    } wr_t;

    function automatic mode_t decode_mode(logic [7:0] sel);
        mode_t m;
        unique case (sel)
            MODE_SEL_TIMED: m = MODE_TIMED;
            MODE_SEL_HW:    m = MODE_HW;
            default:        m = MODE_SOLID;
        endcase
        return m;
    endfunction

    // one restoring step of the percentage division
    function automatic work_t div_step(work_t w, int unsigned sh);
        logic [23:0] trial;
        work_t       r;
        r     = w;
        trial = 24'(w.p_sum) << sh;
        if ({1'b0, w.rem} >= trial)
        begin
            r.rem            = w.rem - trial[22:0];
            r.pct[sh[2:0]]   = 1'b1;
        end
        return r;
    endfunction

    // level * 9 / 255 as ((level * 9 + 1) * 257) >> 16
    function automatic logic [3:0] level_to_step(logic [7:0] lv);
        logic [11:0] y1;
        logic [20:0] prod;
        y1   = 12'(lv) * 12'd9 + 12'd1;
        prod = 21'(y1) * 21'd257;
        return prod[19:16];
    endfunction

    function automatic logic [7:0] make_enable(work_t w);
        logic [1:0] code;
        logic [7:0] en;
        code = (w.mode == MODE_SOLID) ? 2'd1 : 2'd2;
        en   = ENABLE_BIT;
        if (w.red != 8'd0)
        begin
            en = en | {6'd0, code};
        end
        if (w.blue != 8'd0)
        begin
            en = en | {4'd0, code, 2'd0};
        end
        if (w.green != 8'd0)
        begin
            en = en | {2'd0, code, 4'd0};
        end
        return en;
    endfunction

    // write of a given slot in an item's sequence
    function automatic wr_t write_at(seq_t s, logic [3:0] slot);
        wr_t w;
        unique case (slot)
            4'd0: w = '{addr: ADDR_ENABLE, value: 8'd0, last: s.blank};
            4'd1: w = '{addr: ADDR_BLINK, value: BLINK_OFF, last: 1'b0};
            4'd2: w = '{addr: ADDR_RED, value: {4'd0, s.red_step}, last: 1'b0};
            4'd3: w = '{addr: ADDR_GREEN, value: {4'd0, s.green_step}, last: 1'b0};
            4'd4: w = '{addr: ADDR_BLUE, value: {4'd0, s.blue_step}, last: 1'b0};
            4'd5:
            begin
                if (s.flash)
                begin
                    w = '{addr: ADDR_PERIOD, value: s.period, last: 1'b0};
                end
                else
                begin
                    w = '{addr: ADDR_ENABLE, value: s.enable, last: 1'b1};
                end
            end
            4'd6: w = '{addr: ADDR_DUTY, value: 8'd0, last: 1'b0};
            4'd7: w = '{addr: ADDR_ENABLE, value: s.enable, last: 1'b0};
            default: w = '{addr: ADDR_DUTY, value: s.duty, last: 1'b1};
        endcase
        return w;
    endfunction

endpackage

@@ rtl/core/rlbws_if.sv @@
// channel interfaces of the rgb led write sequencer: level triples in, writes out
// depends on nothing
interface rlbws_level_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;

    modport source (output valid, output red_level, output green_level,
                    output blue_level, input ready);
    modport sink (input valid, input red_level, input green_level,
                  input blue_level, output ready);
endinterface

interface rlbws_write_if;
    logic       valid;
    logic       ready;
    logic [3:0] reg_address;
    logic [7:0] reg_value;
    logic       last_write;

    modport source (output valid, output reg_address, output reg_value,
                    output last_write, input ready);
    modport sink (input valid, input reg_address, input reg_value,
                  input last_write, output ready);
endinterface

@@ rtl/core/rlbws_prep.sv @@
// input stage: registers the level triple, sums the flash time, quantises the period
// depends on rlbws_pkg and rlbws_level_if
module rlbws_prep
    import rlbws_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    rlbws_level_if.sink   levels,
    output logic          out_valid,
    input  logic          out_ready,
    output work_t         out_work
);

    logic  v_reg;
    work_t w_reg;
    work_t w_next;
    logic  load;

    assign levels.ready = !v_reg || out_ready;
    assign load         = levels.valid && levels.ready;
    assign out_valid    = v_reg;
    assign out_work     = w_reg;

    always_comb
    begin
        logic [16:0] p_sum;
        logic [16:0] p_clamp;
        p_sum   = {1'b0, cfg.on_time_ms} + {1'b0, cfg.off_time_ms};
        p_clamp = (p_sum > PERIOD_MAX_MS) ? PERIOD_MAX_MS : p_sum;

        w_next       = '0;
        w_next.red   = levels.red_level;
        w_next.green = levels.green_level;
        w_next.blue  = levels.blue_level;
        w_next.blank = (levels.red_level | levels.green_level | levels.blue_level) == 8'd0;
        w_next.mode  = decode_mode(cfg.flash_mode_sel);
        w_next.p_sum = p_sum;
        w_next.rem   = 23'(cfg.on_time_ms) * 23'(PCT_SCALE);
        w_next.pct   = '0;
        priority if (w_next.mode == MODE_HW)
        begin
            w_next.period = HW_PERIOD;
        end
        else if (p_sum < PERIOD_FIRST_MS)
        begin
            w_next.period = 8'd0;
        end
        else
        begin
            w_next.period = 8'(((p_clamp - PERIOD_FIRST_MS) >> PERIOD_SHIFT) + 17'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (levels.ready)
        begin
            v_reg <= levels.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            w_reg <= w_next;
        end
    end

endmodule

@@ rtl/core/rlbws_div.sv @@
// three-stage restoring divider for the on-time percentage (on * 100 / period)
// depends on rlbws_pkg
module rlbws_div
    import rlbws_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  work_t in_work,
    output logic  out_valid,
    input  logic  out_ready,
    output work_t out_work
);

    localparam int NSTAGE = 3;

    logic  v_reg [NSTAGE];
    work_t w_reg [NSTAGE];
    logic  rdy   [NSTAGE];
    work_t stage_out [NSTAGE];

    assign rdy[2]    = !v_reg[2] || out_ready;
    assign rdy[1]    = !v_reg[1] || rdy[2];
    assign rdy[0]    = !v_reg[0] || rdy[1];
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[2];
    assign out_work  = w_reg[2];

    // quotient bits 6..4, 3..1 and 0, one group per stage
    always_comb
    begin
        stage_out[0] = div_step(div_step(div_step(in_work, 6), 5), 4);
        stage_out[1] = div_step(div_step(div_step(w_reg[0], 3), 2), 1);
        stage_out[2] = div_step(w_reg[1], 0);
        // no flash time at all reads as zero percent
        if (w_reg[1].p_sum == 17'd0)
        begin
            stage_out[2].pct = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
            v_reg[1] <= 1'b0;
            v_reg[2] <= 1'b0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            if (rdy[1])
            begin
                v_reg[1] <= v_reg[0];
            end
            if (rdy[2])
            begin
                v_reg[2] <= v_reg[1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < NSTAGE; s++)
        begin
            if (rdy[s])
            begin
                w_reg[s] <= stage_out[s];
            end
        end
    end

endmodule

@@ rtl/core/rlbws_duty.sv @@
// three-stage duty scaling (pct * 425 / 166 by reciprocal) plus step and enable build
// depends on rlbws_pkg
module rlbws_duty
    import rlbws_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  work_t in_work,
    output logic  out_valid,
    input  logic  out_ready,
    output seq_t  out_rec
);

    logic        v0_reg;
    logic        v1_reg;
    logic        v2_reg;
    logic        rdy0;
    logic        rdy1;
    logic        rdy2;
    work_t       w0_reg;
    work_t       w1_reg;
    logic [15:0] scaled0_reg;
    logic [15:0] scaled1_reg;
    logic [8:0]  est1_reg;
    logic [24:0] prod;
    seq_t        rec_next;
    seq_t        rec_reg;

    assign rdy2      = !v2_reg || out_ready;
    assign rdy1      = !v1_reg || rdy2;
    assign rdy0      = !v0_reg || rdy1;
    assign in_ready  = rdy0;
    assign out_valid = v2_reg;
    assign out_rec   = rec_reg;

    // estimate never exceeds the true quotient and is at most one short
    assign prod = 25'(scaled0_reg) * 25'(DUTY_RECIP);

    always_comb
    begin
        logic [16:0] back;
        logic [16:0] rem;
        logic [9:0]  est;
        back = 17'(est1_reg) * 17'(DUTY_DEN);
        rem  = {1'b0, scaled1_reg} - back;
        est  = {1'b0, est1_reg};
        if (rem >= 17'(DUTY_DEN))
        begin
            est = est + 10'd1;
        end

        rec_next.red_step   = level_to_step(w1_reg.red);
        rec_next.green_step = level_to_step(w1_reg.green);
        rec_next.blue_step  = level_to_step(w1_reg.blue);
        rec_next.blank      = w1_reg.blank;
        rec_next.flash      = w1_reg.mode != MODE_SOLID;
        rec_next.period     = w1_reg.period;
        rec_next.enable     = make_enable(w1_reg);
        priority if (w1_reg.mode == MODE_HW)
        begin
            rec_next.duty = HW_DUTY;
        end
        else if (est > 10'd255)
        begin
            rec_next.duty = DUTY_SAT;
        end
        else
        begin
            rec_next.duty = est[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)
            begin
                v0_reg <= in_valid;
            end
            if (rdy1)
            begin
                v1_reg <= v0_reg;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy0)
        begin
            w0_reg      <= in_work;
            scaled0_reg <= 16'(in_work.pct) * 16'(DUTY_NUM);
        end
        if (rdy1)
        begin
            w1_reg      <= w0_reg;
            scaled1_reg <= scaled0_reg;
            est1_reg    <= prod[24:16];
        end
        if (rdy2)
        begin
            rec_reg <= rec_next;
        end
    end

endmodule

@@ rtl/core/rlbws_seq.sv @@
// output sequencer: walks one item's record and emits its writes, one per cycle while writes.ready is high
// depends on rlbws_pkg and rlbws_write_if
module rlbws_seq
    import rlbws_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  seq_t          in_rec,
    rlbws_write_if.source writes
);

    logic       busy_reg;
    logic [3:0] slot_reg;
    seq_t       rec_reg;
    logic       out_valid_reg;
    wr_t        wr_reg;
    wr_t        cur;
    logic       load;
    logic       emit_last;
    logic       take;

    assign cur       = write_at(rec_reg, slot_reg);
    assign load      = !out_valid_reg || writes.ready;
    assign emit_last = load && busy_reg && cur.last;
    // next record is taken in the cycle the last write moves to the output register
    assign in_ready  = !busy_reg || emit_last;
    assign take      = in_valid && in_ready;

    assign writes.valid       = out_valid_reg;
    assign writes.reg_address = wr_reg.addr;
    assign writes.reg_value   = wr_reg.value;
    assign writes.last_write  = wr_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            slot_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= busy_reg;
            end
            if (take)
            begin
                busy_reg <= 1'b1;
                slot_reg <= 4'd0;
            end
            else if (emit_last)
            begin
                busy_reg <= 1'b0;
            end
            else if (load && busy_reg)
            begin
                slot_reg <= slot_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rec_reg <= in_rec;
        end
        if (load && busy_reg)
        begin
            wr_reg <= cur;
        end
    end

endmodule

@@ rtl/core/rgb_led_blink_write_sequencer_unit.sv @@
// rgb led write sequencer: turns a brightness triple into driver register writes
// Channels: levels (sink) carries red_level, green_level, blue_level; writes
// (source) carries reg_address, reg_value and last_write. Both move an item at
// a clock edge where valid and ready are high.
// Configuration: cfg_write_en, cfg_index, cfg_data write flash_mode_sel (0),
// on_time_ms (1) and off_time_ms (2); other indexes are ignored. Change them
// only while no item is in flight.
// Path: the first write of an item is shown once the item has passed the
// input stage, three divider stages, three duty stages and the sequencer.
// Output: one write per cycle from the sequencer while writes.ready is high;
// an item makes 1 write (all levels zero), 6 writes (solid colour) or 9 writes
// (timed or hardware flash); the pipeline in front takes a new item every cycle until it fills.
// Reset: valid bits and the sequencer clear; configuration returns to zero
// (solid colour, zero on and off time).
// Stall: a low ready on writes holds the output register; the sequencer and
// the pipeline behind it fill up and then drop levels.ready, nothing is lost.
// depends on rlbws_pkg, rlbws_if and the rlbws_* submodules
module rgb_led_blink_write_sequencer_unit
    import rlbws_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    rlbws_level_if.sink           levels,
    rlbws_write_if.source         writes
);

    cfg_t  cfg_reg;

    logic  prep_valid;
    logic  prep_ready;
    work_t prep_work;
    logic  div_valid;
    logic  div_ready;
    work_t div_work;
    logic  duty_valid;
    logic  duty_ready;
    seq_t  duty_rec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_MODE: cfg_reg.flash_mode_sel <= cfg_data[7:0];
                CFG_ON:   cfg_reg.on_time_ms     <= cfg_data;
                CFG_OFF:  cfg_reg.off_time_ms    <= cfg_data;
                default:  cfg_reg                <= cfg_reg;
            endcase
        end
    end

    rlbws_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .levels    (levels),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_work  (prep_work)
    );

    rlbws_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_work   (prep_work),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_work  (div_work)
    );

    rlbws_duty u_duty (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_work   (div_work),
        .out_valid (duty_valid),
        .out_ready (duty_ready),
        .out_rec   (duty_rec)
    );

    rlbws_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (duty_valid),
        .in_ready (duty_ready),
        .in_rec   (duty_rec),
        .writes   (writes)
    );

endmodule

@@ bench/rgb_led_blink_write_sequencer_unit_test.sv @@
// self-checking bench for the rgb led write sequencer: directed and random level triples
// under timed, hardware and solid modes, every write checked against a local predictor
// depends on rlbws_pkg, rlbws_if and the rgb_led_blink_write_sequencer_unit rtl
module rgb_led_blink_write_sequencer_unit_test;
    import rlbws_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int unsigned STEP_LEVELS  = 9;
    localparam int unsigned LEVEL_FULL   = 255;
    localparam int unsigned PERIOD_STEP  = 128;
    localparam int unsigned PCT_FULL     = 100;
    localparam int unsigned DUTY_SCALE   = 25500;
    localparam int unsigned DUTY_DIVISOR = 9960;
    localparam logic [7:0]  MODE_SEL_SOLID = 8'd0;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_PHASES = 12;
    localparam int unsigned PHASE_ITEMS   = 36;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rlbws_level_if lvl_ch ();
    rlbws_write_if wr_ch ();

    // local copy of the configuration registers
    logic [7:0]  mode_reg;
    logic [15:0] on_ms_reg;
    logic [15:0] off_ms_reg;

    wr_t         pending_writes[$];
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    bit          throttle_on;

    rgb_led_blink_write_sequencer_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .levels       (lvl_ch.sink),
        .writes       (wr_ch.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("rgb_led_blink_write_sequencer_unit_test NOT OK");
            $finish;
        end
    end

    // write channel back-pressure
    always @(posedge clk)
    begin
        if (throttle_on)
        begin
            wr_ch.ready <= ($urandom_range(99) >= 36);
        end
        else
        begin
            wr_ch.ready <= 1'b1;
        end
    end

    function automatic void push_write(logic [3:0] addr, logic [7:0] value, logic last);
        wr_t w;
        w.addr  = addr;
        w.value = value;
        w.last  = last;
        pending_writes.push_back(w);
    endfunction

    function automatic logic [7:0] current_step(logic [7:0] lv);
        int unsigned s;
        s = (int'(lv) * STEP_LEVELS) / LEVEL_FULL;
        return 8'(s);
    endfunction

    // register-write sequence that one brightness triple should produce
    function automatic void predict_writes(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        bit          flash;
        logic [7:0]  code;
        logic [7:0]  enable;
        int unsigned p_sum;
        int unsigned pct;
        int unsigned period;
        int unsigned duty;
        flash  = (mode_reg == MODE_SEL_TIMED) || (mode_reg == MODE_SEL_HW);
        code   = flash ? 8'd2 : 8'd1;
        enable = ENABLE_BIT;
        period = 0;
        duty   = 0;
        if (r == 8'd0 && g == 8'd0 && b == 8'd0)
        begin
            push_write(ADDR_ENABLE, 8'd0, 1'b1);
            return;
        end
        if (r != 8'd0)
        begin
            enable = enable | code;
        end
        if (b != 8'd0)
        begin
            enable = enable | (code << 2);
        end
        if (g != 8'd0)
        begin
            enable = enable | (code << 4);
        end
        if (mode_reg == MODE_SEL_TIMED)
        begin
            p_sum = 32'(on_ms_reg) + 32'(off_ms_reg);
            // percentage is taken before the period clamp
            pct = (p_sum != 0) ? (32'(on_ms_reg) * PCT_FULL) / p_sum : 0;
            if (p_sum >= 32'(PERIOD_FIRST_MS))
            begin
                if (p_sum > 32'(PERIOD_MAX_MS))
                begin
                    p_sum = 32'(PERIOD_MAX_MS);
                end
                period = (p_sum - 32'(PERIOD_FIRST_MS)) / PERIOD_STEP + 1;
            end
            duty = (pct * DUTY_SCALE) / DUTY_DIVISOR;
            if (duty > 32'(DUTY_SAT))
            begin
                duty = 32'(DUTY_SAT);
            end
        end
        else if (mode_reg == MODE_SEL_HW)
        begin
            period = 32'(HW_PERIOD);
            duty   = 32'(HW_DUTY);
        end
        push_write(ADDR_ENABLE, 8'd0, 1'b0);
        push_write(ADDR_BLINK, BLINK_OFF, 1'b0);
        push_write(ADDR_RED, current_step(r), 1'b0);
        push_write(ADDR_GREEN, current_step(g), 1'b0);
        push_write(ADDR_BLUE, current_step(b), 1'b0);
        if (!flash)
        begin
            push_write(ADDR_ENABLE, enable, 1'b1);
            return;
        end
        push_write(ADDR_PERIOD, 8'(period), 1'b0);
        push_write(ADDR_DUTY, 8'd0, 1'b0);
        push_write(ADDR_ENABLE, enable, 1'b0);
        push_write(ADDR_DUTY, 8'(duty), 1'b1);
    endfunction

    // compare every accepted write with the oldest expected one
    always @(posedge clk)
    begin : check_writes
        wr_t want;
        if (rst_n && wr_ch.valid && wr_ch.ready)
        begin
            if (pending_writes.size() == 0)
            begin
                $error("unexpected write: addr %0d value 0x%02h last %0b",
                       wr_ch.reg_address, wr_ch.reg_value, wr_ch.last_write);
                fail_count = fail_count + 1;
            end
            else
            begin
                want = pending_writes.pop_front();
                if (wr_ch.reg_address !== want.addr)
                begin
                    $error("reg_address: expected %0d, got %0d", want.addr, wr_ch.reg_address);
                    fail_count = fail_count + 1;
                end
                if (wr_ch.reg_value !== want.value)
                begin
                    $error("reg_value: expected 0x%02h, got 0x%02h", want.value, wr_ch.reg_value);
                    fail_count = fail_count + 1;
                end
                if (wr_ch.last_write !== want.last)
                begin
                    $error("last_write: expected %0b, got %0b", want.last, wr_ch.last_write);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    // offer one triple, with a random gap in front, and hold it until taken
    task automatic send_levels(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        while (throttle_on && $urandom_range(99) < 36)
        begin
            lvl_ch.valid <= 1'b0;
            @(posedge clk);
        end
        lvl_ch.valid       <= 1'b1;
        lvl_ch.red_level   <= r;
        lvl_ch.green_level <= g;
        lvl_ch.blue_level  <= b;
        @(posedge clk);
        while (!lvl_ch.ready)
        begin
            @(posedge clk);
        end
        predict_writes(r, g, b);
    endtask

    // let every expected write come out, then let the pipeline settle
    task automatic drain_block();
        lvl_ch.valid <= 1'b0;
        while (pending_writes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(posedge clk);
        if (idx == CFG_MODE)
        begin
            mode_reg = data[7:0];
        end
        else if (idx == CFG_ON)
        begin
            on_ms_reg = data;
        end
        else if (idx == CFG_OFF)
        begin
            off_ms_reg = data;
        end
    endtask

    task automatic set_config(input logic [7:0] mode, input logic [15:0] on_ms,
                              input logic [15:0] off_ms);
        drain_block();
        write_reg(CFG_MODE, {8'd0, mode});
        write_reg(CFG_ON, on_ms);
        write_reg(CFG_OFF, off_ms);
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        send_levels(8'd255, 8'd255, 8'd255);
        send_levels(8'd0, 8'd0, 8'd0);
        send_levels(8'd1, 8'd0, 8'd0);
    endtask

    // step boundaries sit at 28/29 and 254/255
    task automatic test_solid_levels();
        set_config(MODE_SEL_SOLID, 16'hFFFF, 16'hFFFF);
        send_levels(8'd0, 8'd0, 8'd0);
        send_levels(8'd255, 8'd255, 8'd255);
        send_levels(8'd28, 8'd29, 8'd0);
        send_levels(8'd0, 8'd254, 8'd1);
        send_levels(8'd0, 8'd0, 8'd128);
    endtask

    task automatic test_timed_flash();
        // zero period gives zero duty
        set_config(MODE_SEL_TIMED, 16'd0, 16'd0);
        send_levels(8'd200, 8'd0, 8'd0);
        // all on saturates the duty
        set_config(MODE_SEL_TIMED, 16'hFFFF, 16'd0);
        send_levels(8'd0, 8'd90, 8'd0);
        set_config(MODE_SEL_TIMED, 16'd100, 16'd283);
        send_levels(8'd0, 8'd0, 8'd77);
        set_config(MODE_SEL_TIMED, 16'd192, 16'd192);
        send_levels(8'd17, 8'd34, 8'd51);
        set_config(MODE_SEL_TIMED, 16'd8190, 16'd8190);
        send_levels(8'd255, 8'd1, 8'd0);
        set_config(MODE_SEL_TIMED, 16'd16380, 16'd1);
        send_levels(8'd0, 8'd0, 8'd0);
        // sum past the clamp, percentage from the full sum
        set_config(MODE_SEL_TIMED, 16'hFFFF, 16'hFFFF);
        send_levels(8'd99, 8'd150, 8'd255);
    endtask

    task automatic test_hw_flash();
        set_config(MODE_SEL_HW, 16'd1234, 16'd4321);
        send_levels(8'd255, 8'd255, 8'd255);
        send_levels(8'd0, 8'd1, 8'd0);
    endtask

    // unknown selectors fall back to solid; index 3 must change nothing
    task automatic test_unknown_mode();
        set_config(8'd255, 16'd500, 16'd500);
        write_reg(CFG_UNUSED, 16'h0001);
        cfg_write_en <= 1'b0;
        @(posedge clk);
        send_levels(8'd60, 8'd0, 8'd240);
        set_config(8'd3, 16'd0, 16'd0);
        write_reg(CFG_UNUSED, 16'hFFFE);
        cfg_write_en <= 1'b0;
        @(posedge clk);
        send_levels(8'd0, 8'd200, 8'd0);
    endtask

    function automatic logic [7:0] pick_level();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 20)
        begin
            return 8'd0;
        end
        else if (sel < 28)
        begin
            return 8'd255;
        end
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [15:0] pick_time_ms();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel == 0)
        begin
            return 16'd0;
        end
        else if (sel < 4)
        begin
            return 16'($urandom_range(600));
        end
        else if (sel < 7)
        begin
            return 16'($urandom_range(9000));
        end
        return 16'($urandom_range(65535));
    endfunction

    function automatic logic [7:0] pick_mode();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel < 4)
        begin
            return MODE_SEL_TIMED;
        end
        else if (sel < 6)
        begin
            return MODE_SEL_HW;
        end
        else if (sel < 8)
        begin
            return MODE_SEL_SOLID;
        end
        return 8'($urandom_range(255));
    endfunction

    task automatic test_random_traffic();
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            set_config(pick_mode(), pick_time_ms(), pick_time_ms());
            // one phase runs with no idling on either side
            throttle_on = (ph != RANDOM_PHASES / 2);
            for (int unsigned n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(19) == 0)
                begin
                    r = 8'd0;
                    g = 8'd0;
                    b = 8'd0;
                end
                else
                begin
                    r = pick_level();
                    g = pick_level();
                    b = pick_level();
                end
                send_levels(r, g, b);
            end
            throttle_on = 1'b1;
        end
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        cfg_write_en       <= 1'b0;
        cfg_index          <= CFG_MODE;
        cfg_data           <= '0;
        lvl_ch.valid       <= 1'b0;
        lvl_ch.red_level   <= 8'd0;
        lvl_ch.green_level <= 8'd0;
        lvl_ch.blue_level  <= 8'd0;
        mode_reg    = MODE_SEL_SOLID;
        on_ms_reg   = 16'd0;
        off_ms_reg  = 16'd0;
        throttle_on = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_solid_levels();
        test_timed_flash();
        test_hw_flash();
        test_unknown_mode();
        test_random_traffic();
        drain_block();

        if (pending_writes.size() != 0)
        begin
            $error("%0d expected writes never arrived", pending_writes.size());
            fail_count = fail_count + 1;
        end
        if (fail_count == 0)
        begin
            $display("rgb_led_blink_write_sequencer_unit_test OK");
        end
        else
        begin
            $display("rgb_led_blink_write_sequencer_unit_test NOT OK");
        end
        $finish;
    end

endmodule
